// ===== sv/bdd_pkg.sv =====
package bdd_pkg;

    localparam int MAX_BYTES_DEF  = 8;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int QUEUE_DEPTH    = 2;
    localparam int BITS_PER_BYTE  = 8;

    localparam logic [3:0] BCD_TEN  = 4'd10;
    localparam logic [3:0] BCD_NINE = 4'd9;
    localparam logic [3:0] BCD_FIVE = 4'd5;

    // one queued byte as the front part classified it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } bdd_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } bdd_state_t;

endpackage

// ===== sv/bdd_queue.sv =====
module bdd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bdd_pkg::bdd_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output bdd_pkg::bdd_entry_t pop_entry,
    output logic                empty
);
    import bdd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bdd_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/bdd_front.sv =====
module bdd_front #(
    parameter int MAX_BYTES = bdd_pkg::MAX_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    output logic                push,
    output bdd_pkg::bdd_entry_t push_entry,
    input  logic                full
);
    import bdd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    logic [CNT_W-1:0] taken_reg;
    logic [CNT_W-1:0] taken_next;
    logic             accept;
    logic             drop;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    // bytes past the limit are still queued so the back end sees the flag and the end mark
    assign drop     = (taken_reg >= CNT_W'(MAX_BYTES));

    assign push            = accept;
    assign push_entry.data = s_tdata;
    assign push_entry.last = s_tlast;
    assign push_entry.drop = drop;

    always_comb
    begin
        taken_next = taken_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                taken_next = '0;
            end
            else if (!drop)
            begin
                taken_next = taken_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

endmodule

// ===== sv/bdd_back.sv =====
module bdd_back #(
    parameter int MAX_DIGITS = bdd_pkg::MAX_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  bdd_pkg::bdd_entry_t pop_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import bdd_pkg::*;

    localparam int DW = 4 * MAX_DIGITS;

    bdd_state_t       state_reg;
    bdd_state_t       state_next;
    logic [DW-1:0]    sum_reg;
    logic [DW-1:0]    sum_next;
    logic [DW-1:0]    pow_reg;
    logic [DW-1:0]    pow_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic [2:0]       bit_cnt_reg;
    logic [2:0]       bit_cnt_next;
    logic             last_reg;
    logic             last_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic [DW-1:0]    sum_add;
    logic [DW-1:0]    pow_dbl;
    logic [MAX_DIGITS:0] carry;
    logic [4:0]       pair [MAX_DIGITS];
    logic [4:0]       total [MAX_DIGITS];
    logic [4:0]       twice [MAX_DIGITS];
    logic             upper_zero;
    logic             out_fire;

    // decimal add with generate/propagate carries, like a binary adder
    always_comb
    begin
        carry[0] = 1'b0;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            pair[k]     = {1'b0, sum_reg[4*k +: 4]} + {1'b0, pow_reg[4*k +: 4]};
            carry[k+1]  = (pair[k] >= {1'b0, BCD_TEN})
                        || ((pair[k] == {1'b0, BCD_NINE}) && carry[k]);
            total[k]    = pair[k] + {4'd0, carry[k]};
            sum_add[4*k +: 4] = carry[k+1] ? 4'(total[k] - {1'b0, BCD_TEN}) : total[k][3:0];
        end
    end

    // doubling: the carry into a digit depends only on the digit below
    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            twice[k] = {pow_reg[4*k +: 4], 1'b0};
            if (k > 0)
            begin
                twice[k] = twice[k] + {4'd0, (pow_reg[4*(k-1) +: 4] >= BCD_FIVE)};
            end
            pow_dbl[4*k +: 4] = (pow_reg[4*k +: 4] >= BCD_FIVE)
                              ? 4'(twice[k] - {1'b0, BCD_TEN}) : twice[k][3:0];
        end
    end

    assign upper_zero = (sum_reg[DW-1:4] == '0);
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign m_tdata    = {4'd0, sum_reg[3:0]};
    assign m_tlast    = upper_zero;
    assign m_tuser    = ovf_reg;
    assign out_fire   = m_tvalid && m_tready;

    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        pow_next     = pow_reg;
        byte_next    = byte_reg;
        bit_cnt_next = bit_cnt_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (pop_entry.drop)
                    begin
                        ovf_next = 1'b1;
                        if (pop_entry.last)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        byte_next    = pop_entry.data;
                        last_next    = pop_entry.last;
                        bit_cnt_next = '0;
                        state_next   = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (byte_reg[0])
                begin
                    sum_next = sum_add;
                end
                pow_next     = pow_dbl;
                byte_next    = {1'b0, byte_reg[7:1]};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 3'(BITS_PER_BYTE - 1))
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    sum_next = {4'd0, sum_reg[DW-1:4]};
                    if (upper_zero)
                    begin
                        sum_next   = '0;
                        pow_next   = DW'(1);
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            pow_reg     <= DW'(1);
            ovf_reg     <= 1'b0;
            bit_cnt_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            pow_reg     <= pow_next;
            ovf_reg     <= ovf_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= BCD_NINE))
        else $error("emitted digit is not decimal");

    a_clear_after_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_tlast |=> (sum_reg == '0) && (pow_reg == DW'(1)) && !ovf_reg)
        else $error("state not cleared after the last digit");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE) && !empty)
        else $error("queue popped outside idle or while empty");

endmodule

// ===== sv/binary_to_decimal_digits.sv =====
// channel  | dir | tdata            | tlast       | tuser
// s_axis   | in  | [7:0] data_byte  | last_byte   | -
// m_axis   | out | [3:0] digit      | last_digit  | overflow_flag
//
// a byte within the limit is popped from the queue by the back end and then runs
// through eight bit steps of the shared decimal add/double unit; a dropped byte is only popped
// the number then comes out one digit per cycle while m_tready is high, least significant first
// a two-entry queue sits between the byte classifier and the back end, so input
// can still be taken until the queue fills while digits wait on m_tready
// rst_n clears the queue, counters and the decimal sum, and sets the power register to one
module binary_to_decimal_digits #(
    parameter int MAX_BYTES  = bdd_pkg::MAX_BYTES_DEF,
    parameter int MAX_DIGITS = bdd_pkg::MAX_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] digit, [7:4] zero
    output logic       m_tlast,
    output logic       m_tuser    // [0] overflow_flag
);
    import bdd_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    bdd_entry_t q_in;
    bdd_entry_t q_out;

    bdd_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full)
    );

    bdd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    bdd_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .pop_entry (q_out),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
